/* src/variable_message_stream_parser_assert.svh */
// Assertion macros for the stream parser checker.
`ifndef VARIABLE_MESSAGE_STREAM_PARSER_ASSERT_SVH
`define VARIABLE_MESSAGE_STREAM_PARSER_ASSERT_SVH
`define VMSP_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define VMSP_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* src/vmsp_pkg.sv */
// ----------------------------------------------------------------------------
// vmsp_pkg
// Shared types and constants of the variable message stream parser.
// ----------------------------------------------------------------------------
package vmsp_pkg;
  localparam int unsigned FifoDepth = 2;
  localparam logic [31:0] HeaderBytes = 32'd12;
  localparam logic [31:0] TypeWordBytes = 32'd4;

  localparam logic [1:0] EV_FRAME = 2'd0;
  localparam logic [1:0] EV_NAME  = 2'd1;
  localparam logic [1:0] EV_VALUE = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_SHORT = 3'd1;
  localparam logic [2:0] ERR_TYPE  = 3'd2;
  localparam logic [2:0] ERR_SIZE  = 3'd3;
  localparam logic [2:0] ERR_TRUNC = 3'd4;

  localparam logic [1:0] CFG_SWAP = 2'd0;
  localparam logic [1:0] CFG_NONAMES = 2'd1;
  localparam logic [1:0] CFG_MIN = 2'd2;
  localparam logic [1:0] CFG_MAX = 2'd3;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  byte_out;
    logic [31:0] var_number;
    logic [31:0] var_type_code;
    logic [31:0] var_length;
    logic [31:0] byte_offset;
    logic        var_last;
    logic [31:0] msg_type;
    logic        message_done;
    logic [2:0]  error_code;
  } result_t;
endpackage

/* src/vmsp_parser.sv */
// ----------------------------------------------------------------------------
// vmsp_parser
// Front end: accepts bytes, tracks framing state and builds one result each.
// ----------------------------------------------------------------------------
module vmsp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                swap_bytes,
  input  logic                no_names,
  input  logic [31:0]         min_type_code,
  input  logic [31:0]         max_type_code,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output vmsp_pkg::result_t   res
);
  localparam logic [3:0] PH_MSG_TYPE = 4'd0;
  localparam logic [3:0] PH_MSG_SIZE = 4'd1;
  localparam logic [3:0] PH_VAR_COUNT = 4'd2;
  localparam logic [3:0] PH_NAME_LEN = 4'd3;
  localparam logic [3:0] PH_NAME = 4'd4;
  localparam logic [3:0] PH_VAR_TYPE = 4'd5;
  localparam logic [3:0] PH_VAR_SIZE = 4'd6;
  localparam logic [3:0] PH_VALUE = 4'd7;
  localparam logic [3:0] PH_DONE = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  wcnt_r, wcnt_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] cvar_r, cvar_nxt;
  logic [31:0] vtot_r, vtot_nxt;
  logic [31:0] htype_r, htype_nxt;
  logic [31:0] hsize_r, hsize_nxt;
  logic [31:0] hmtype_r, hmtype_nxt;
  logic [31:0] hmsize_r, hmsize_nxt;
  logic        terr_r, terr_nxt;

  logic [31:0] word;
  logic        wdone;
  logic [31:0] cvar_inc;
  logic [3:0]  begin_ph;

  always_comb begin
    if (swap_bytes) word = {shift_r[23:0], data_byte};
    else begin
      word = shift_r;
      unique case (wcnt_r)
        2'd0: word[7:0] = data_byte;
        2'd1: word[15:8] = data_byte;
        2'd2: word[23:16] = data_byte;
        default: word[31:24] = data_byte;
      endcase
    end
    wdone = (wcnt_r == 2'd3);
  end

  assign cvar_inc = cvar_r + 32'd1;
  assign begin_ph = no_names ? PH_VAR_TYPE : PH_NAME_LEN;

  always_comb begin
    logic take;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    wcnt_nxt = wcnt_r;
    total_nxt = (total_r == 32'hFFFF_FFFF) ? total_r : total_r + 32'd1;
    rem_nxt = rem_r;
    cvar_nxt = cvar_r;
    vtot_nxt = vtot_r;
    htype_nxt = htype_r;
    hsize_nxt = hsize_r;
    hmtype_nxt = hmtype_r;
    hmsize_nxt = hmsize_r;
    terr_nxt = terr_r;
    res = '0;
    res.byte_out = data_byte;
    take = (phase_r == PH_MSG_TYPE) || (phase_r == PH_MSG_SIZE) ||
           (phase_r == PH_VAR_COUNT) || (phase_r == PH_NAME_LEN) ||
           (phase_r == PH_VAR_TYPE) || (phase_r == PH_VAR_SIZE);
    if (take) begin
      shift_nxt = wdone ? 32'd0 : word;
      wcnt_nxt = wcnt_r + 2'd1;
    end
    unique case (phase_r)
      PH_MSG_TYPE: if (wdone) begin
        hmtype_nxt = word;
        if (word < min_type_code || word > max_type_code) terr_nxt = 1'b1;
        phase_nxt = PH_MSG_SIZE;
      end
      PH_MSG_SIZE: if (wdone) begin
        hmsize_nxt = word;
        phase_nxt = PH_VAR_COUNT;
      end
      PH_VAR_COUNT: if (wdone) begin
        vtot_nxt = word;
        cvar_nxt = '0;
        phase_nxt = (word == 32'd0) ? PH_DONE : begin_ph;
      end
      PH_NAME_LEN: if (wdone) begin
        hsize_nxt = word;
        rem_nxt = word;
        phase_nxt = (word == 32'd0) ? PH_VAR_TYPE : PH_NAME;
      end
      PH_NAME: begin
        res.event_res = vmsp_pkg::EV_NAME;
        res.var_number = cvar_r;
        res.byte_offset = hsize_r - rem_r;
        rem_nxt = rem_r - 32'd1;
        if (rem_r == 32'd1) phase_nxt = PH_VAR_TYPE;
      end
      PH_VAR_TYPE: if (wdone) begin
        htype_nxt = word;
        phase_nxt = PH_VAR_SIZE;
      end
      PH_VAR_SIZE: if (wdone) begin
        hsize_nxt = word;
        rem_nxt = word;
        if (word == 32'd0) begin
          cvar_nxt = cvar_inc;
          phase_nxt = (cvar_inc == vtot_r) ? PH_DONE : begin_ph;
        end else phase_nxt = PH_VALUE;
      end
      PH_VALUE: begin
        res.event_res = vmsp_pkg::EV_VALUE;
        res.var_number = cvar_r;
        res.var_type_code = htype_r;
        res.var_length = hsize_r;
        res.byte_offset = hsize_r - rem_r;
        rem_nxt = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          res.var_last = 1'b1;
          cvar_nxt = cvar_inc;
          phase_nxt = (cvar_inc == vtot_r) ? PH_DONE : begin_ph;
        end
      end
      default: phase_nxt = PH_DONE;
    endcase
    // message type field includes a type word completed by this byte
    res.msg_type = hmtype_nxt;
    if (last_byte) begin
      if (total_nxt < vmsp_pkg::HeaderBytes) res.error_code = vmsp_pkg::ERR_SHORT;
      else if (terr_nxt) res.error_code = vmsp_pkg::ERR_TYPE;
      else if (total_nxt - vmsp_pkg::TypeWordBytes != hmsize_nxt)
        res.error_code = vmsp_pkg::ERR_SIZE;
      else if (phase_nxt != PH_DONE) res.error_code = vmsp_pkg::ERR_TRUNC;
      else res.error_code = vmsp_pkg::ERR_NONE;
      res.message_done = (res.error_code == vmsp_pkg::ERR_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r <= PH_MSG_TYPE;
      shift_r <= '0; wcnt_r <= '0; total_r <= '0; rem_r <= '0;
      cvar_r <= '0; vtot_r <= '0; htype_r <= '0; hsize_r <= '0;
      hmtype_r <= '0; hmsize_r <= '0; terr_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt; wcnt_r <= wcnt_nxt; total_r <= total_nxt;
      rem_r <= rem_nxt; cvar_r <= cvar_nxt; vtot_r <= vtot_nxt;
      htype_r <= htype_nxt; hsize_r <= hsize_nxt; hmtype_r <= hmtype_nxt;
      hmsize_r <= hmsize_nxt; terr_r <= terr_nxt;
    end
  end
endmodule

/* src/vmsp_fifo.sv */
// ----------------------------------------------------------------------------
// vmsp_fifo
// Result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module vmsp_fifo #(
  parameter int unsigned Depth = vmsp_pkg::FifoDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  vmsp_pkg::result_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output vmsp_pkg::result_t rd_data
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  vmsp_pkg::result_t mem_r [Depth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (Aw+1)'(Depth)) || rd;
  assign rd_valid = (cnt_r != '0);
  assign rd = rd_valid && rd_ready;
  assign wr = wr_valid && wr_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == Aw'(Depth - 1)) ? '0 : wp_r + Aw'(1);
      if (rd) rp_r <= (rp_r == Aw'(Depth - 1)) ? '0 : rp_r + Aw'(1);
      cnt_r <= cnt_r + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule

/* src/variable_message_stream_parser.sv */
// ----------------------------------------------------------------------------
// variable_message_stream_parser
// Byte-serial message parser with a result queue toward the output side.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid/in_ready      in_data_byte, in_last_byte
// out      out  out_valid/out_ready    out_* result fields
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
// One byte per cycle while in_ready is high; each byte is parsed in the cycle
// it is accepted and its result is queued behind any earlier ones for out.
// The result queue (FifoDepth entries) sets how long out may stall before
// in_ready drops. Synchronous active-low reset clears state, cfg to defaults.
// ----------------------------------------------------------------------------
module variable_message_stream_parser #(
  parameter int unsigned FifoDepth = vmsp_pkg::FifoDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_byte_out,
  output logic [31:0] out_var_number,
  output logic [31:0] out_var_type_code,
  output logic [31:0] out_var_length,
  output logic [31:0] out_byte_offset,
  output logic        out_var_last,
  output logic [31:0] out_msg_type,
  output logic        out_message_done,
  output logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic swap_r, nonames_r;
  logic [31:0] min_r, max_r;
  vmsp_pkg::result_t pres, ores;
  logic step;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0; nonames_r <= 1'b0; min_r <= '0; max_r <= 32'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vmsp_pkg::CFG_SWAP: swap_r <= cfg_data[0];
        vmsp_pkg::CFG_NONAMES: nonames_r <= cfg_data[0];
        vmsp_pkg::CFG_MIN: min_r <= cfg_data;
        default: max_r <= cfg_data;
      endcase
    end
  end

  assign step = in_valid && in_ready;

  vmsp_parser u_parser (
    .clk, .rst_n, .swap_bytes(swap_r), .no_names(nonames_r),
    .min_type_code(min_r), .max_type_code(max_r), .step,
    .data_byte(in_data_byte), .last_byte(in_last_byte), .res(pres)
  );

  vmsp_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk, .rst_n, .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(pres),
    .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(ores)
  );

  assign out_event_res = ores.event_res;
  assign out_byte_out = ores.byte_out;
  assign out_var_number = ores.var_number;
  assign out_var_type_code = ores.var_type_code;
  assign out_var_length = ores.var_length;
  assign out_byte_offset = ores.byte_offset;
  assign out_var_last = ores.var_last;
  assign out_msg_type = ores.msg_type;
  assign out_message_done = ores.message_done;
  assign out_error_code = ores.error_code;
endmodule

/* src/vmsp_checker.sv */
// ----------------------------------------------------------------------------
// vmsp_checker
// Port-level checks of the stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "variable_message_stream_parser_assert.svh"
module vmsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic       out_var_last,
  input logic       out_message_done,
  input logic [2:0] out_error_code
);
  `VMSP_ASSERT_IMPL(a_done_no_err, out_valid && out_message_done, out_error_code == vmsp_pkg::ERR_NONE)
  `VMSP_ASSERT_IMPL(a_ev_range, out_valid, out_event_res <= vmsp_pkg::EV_VALUE)
  `VMSP_ASSERT_IMPL(a_vlast_value, out_valid && out_var_last, out_event_res == vmsp_pkg::EV_VALUE)
  `VMSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_error_code))
endmodule

bind variable_message_stream_parser vmsp_checker u_vmsp_checker (.*);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Variable message stream parser testbench
// Drives byte-serial messages (well-formed, broken and noise) through the
// parser under several register settings, predicts every per-byte result
// in a scoreboard and compares all fields in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  localparam logic [3:0] PH_MTYPE = 4'd0, PH_MSIZE = 4'd1, PH_VCOUNT = 4'd2,
                         PH_NLEN = 4'd3, PH_NAME = 4'd4, PH_VTYPE = 4'd5,
                         PH_VSIZE = 4'd6, PH_VALUE = 4'd7, PH_DONE = 4'd8;
  localparam int unsigned IdleLimit = 20000;

  class parser_scoreboard;
    bit         swap_mode, nameless;
    bit [31:0]  type_lo, type_hi;
    logic [3:0] phase;
    bit [31:0]  shreg;
    bit [1:0]   nbytes;
    bit [31:0]  total, remain, var_idx, var_cnt, vtype, vsize, mtype, msize;
    bit [2:0]   err_hold;
    vmsp_pkg::result_t pending[$];
    int         errors, checked, msgs, done_msgs;

    function void clear_msg();
      phase = PH_MTYPE; shreg = 0; nbytes = 0; total = 0; remain = 0;
      var_idx = 0; var_cnt = 0; vtype = 0; vsize = 0; mtype = 0; msize = 0;
      err_hold = vmsp_pkg::ERR_NONE;
    endfunction

    function void reset_all();
      swap_mode = 0; nameless = 0; type_lo = 0; type_hi = 255;
      clear_msg();
    endfunction

    function void write_reg(logic [1:0] idx, bit [31:0] v);
      case (idx)
        vmsp_pkg::CFG_SWAP:    swap_mode = v[0];
        vmsp_pkg::CFG_NONAMES: nameless = v[0];
        vmsp_pkg::CFG_MIN:     type_lo = v;
        vmsp_pkg::CFG_MAX:     type_hi = v;
        default: ;
      endcase
    endfunction

    function bit shift_in(bit [7:0] b, output bit [31:0] w);
      if (swap_mode) shreg = {shreg[23:0], b};
      else shreg |= 32'(b) << (8 * nbytes);
      nbytes++;
      w = shreg;
      if (nbytes == 0) begin
        shreg = 0;
        return 1;
      end
      return 0;
    endfunction

    function void next_var();
      var_idx++;
      if (var_idx == var_cnt) phase = PH_DONE;
      else phase = nameless ? PH_VTYPE : PH_NLEN;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      vmsp_pkg::result_t r;
      bit [31:0] w;
      r = '0;
      r.byte_out = b;
      r.event_res = vmsp_pkg::EV_FRAME;
      if (total != 32'hFFFF_FFFF) total++;
      case (phase)
        PH_MTYPE: if (shift_in(b, w)) begin
          mtype = w;
          if (w < type_lo || w > type_hi) err_hold = vmsp_pkg::ERR_TYPE;
          phase = PH_MSIZE;
        end
        PH_MSIZE: if (shift_in(b, w)) begin
          msize = w; phase = PH_VCOUNT;
        end
        PH_VCOUNT: if (shift_in(b, w)) begin
          var_cnt = w; var_idx = 0;
          phase = (w == 0) ? PH_DONE : (nameless ? PH_VTYPE : PH_NLEN);
        end
        PH_NLEN: if (shift_in(b, w)) begin
          vsize = w; remain = w; phase = (w == 0) ? PH_VTYPE : PH_NAME;
        end
        PH_NAME: begin
          r.event_res = vmsp_pkg::EV_NAME; r.var_number = var_idx;
          r.byte_offset = vsize - remain;
          remain--;
          if (remain == 0) phase = PH_VTYPE;
        end
        PH_VTYPE: if (shift_in(b, w)) begin
          vtype = w; phase = PH_VSIZE;
        end
        PH_VSIZE: if (shift_in(b, w)) begin
          vsize = w; remain = w;
          if (w == 0) next_var(); else phase = PH_VALUE;
        end
        PH_VALUE: begin
          r.event_res = vmsp_pkg::EV_VALUE; r.var_number = var_idx;
          r.var_type_code = vtype; r.var_length = vsize;
          r.byte_offset = vsize - remain;
          remain--;
          if (remain == 0) begin
            r.var_last = 1; next_var();
          end
        end
        default: phase = PH_DONE;
      endcase
      r.msg_type = mtype;
      if (last) begin
        if (total < vmsp_pkg::HeaderBytes) r.error_code = vmsp_pkg::ERR_SHORT;
        else if (err_hold == vmsp_pkg::ERR_TYPE) r.error_code = vmsp_pkg::ERR_TYPE;
        else if (total - vmsp_pkg::TypeWordBytes != msize)
          r.error_code = vmsp_pkg::ERR_SIZE;
        else if (phase != PH_DONE) r.error_code = vmsp_pkg::ERR_TRUNC;
        r.message_done = (r.error_code == vmsp_pkg::ERR_NONE);
        msgs++;
        if (r.message_done) done_msgs++;
        clear_msg();
      end
      pending.push_back(r);
    endfunction

    function void check_result(vmsp_pkg::result_t got);
      vmsp_pkg::result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got !== e) begin
        errors++;
        if (got.event_res !== e.event_res)
          $display("%0t: event_res exp %0d got %0d", $time, e.event_res, got.event_res);
        if (got.byte_out !== e.byte_out)
          $display("%0t: byte_out exp %h got %h", $time, e.byte_out, got.byte_out);
        if (got.var_number !== e.var_number)
          $display("%0t: var_number exp %0d got %0d", $time, e.var_number, got.var_number);
        if (got.var_type_code !== e.var_type_code)
          $display("%0t: var_type_code exp %h got %h", $time, e.var_type_code,
                   got.var_type_code);
        if (got.var_length !== e.var_length)
          $display("%0t: var_length exp %0d got %0d", $time, e.var_length, got.var_length);
        if (got.byte_offset !== e.byte_offset)
          $display("%0t: byte_offset exp %0d got %0d", $time, e.byte_offset,
                   got.byte_offset);
        if (got.var_last !== e.var_last)
          $display("%0t: var_last exp %0d got %0d", $time, e.var_last, got.var_last);
        if (got.msg_type !== e.msg_type)
          $display("%0t: msg_type exp %h got %h", $time, e.msg_type, got.msg_type);
        if (got.message_done !== e.message_done)
          $display("%0t: message_done exp %0d got %0d", $time, e.message_done,
                   got.message_done);
        if (got.error_code !== e.error_code)
          $display("%0t: error_code exp %0d got %0d", $time, e.error_code, got.error_code);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_last_byte;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready;
  logic [1:0]  out_event_res;
  logic [7:0]  out_byte_out;
  logic [31:0] out_var_number, out_var_type_code, out_var_length, out_byte_offset;
  logic        out_var_last, out_message_done;
  logic [31:0] out_msg_type;
  logic [2:0]  out_error_code;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  variable_message_stream_parser dut (.*);

  parser_scoreboard sb;
  int  idle_cycles;
  int  bytes_sent;
  bit  out_stall_on;
  byte msg_buf[$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 2);
    return $urandom_range(3, 30);
  endfunction

  // valid stays up after acceptance; the next call either replaces the
  // payload in the same step or drops valid for the gap
  task automatic push_byte(bit [7:0] b, bit last);
    int gap;
    gap = out_stall_on ? pick_gap() : 0;
    cfg_valid <= 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_data_byte <= b; in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    cfg_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, bit [31:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task automatic add_word(bit [31:0] w);
    for (int i = 0; i < 4; i++)
      msg_buf.push_back(sb.swap_mode ? w[31 - 8*i -: 8] : w[8*i +: 8]);
  endtask

  // Builds a message; damage selects a flaw: 0 none, 1 bad type, 2 bad size,
  // 3 truncation, 4 cut inside header, 5 trailing junk.
  task automatic build_msg(int nvars, int damage, int maxlen);
    bit [31:0] mt, n, s;
    int cut;
    msg_buf.delete();
    mt = (sb.type_hi >= sb.type_lo) ? sb.type_lo + $urandom_range(0,
           (sb.type_hi - sb.type_lo > 1000) ? 1000 : sb.type_hi - sb.type_lo) : $urandom;
    if (damage == 1) mt = (sb.type_hi != 32'hFFFF_FFFF) ? sb.type_hi + 1 : sb.type_lo - 1;
    add_word(mt); add_word(0); add_word(nvars);
    for (int v = 0; v < nvars; v++) begin
      if (!sb.nameless) begin
        n = $urandom_range(0, maxlen);
        add_word(n);
        repeat (n) msg_buf.push_back($urandom);
      end
      add_word($urandom);
      s = $urandom_range(0, maxlen);
      add_word(s);
      repeat (s) msg_buf.push_back($urandom);
    end
    if (damage == 5) repeat ($urandom_range(1, 5)) msg_buf.push_back($urandom);
    if (damage == 3 && msg_buf.size() > 12)
      msg_buf = msg_buf[0:$urandom_range(12, msg_buf.size() - 2)];
    if (damage == 4) msg_buf = msg_buf[0:$urandom_range(0, 10)];
    // patch the size word so that size = total - 4
    s = msg_buf.size() - 4;
    if (damage == 2) s = s + $urandom_range(1, 3);
    if (msg_buf.size() >= 8)
      for (int i = 0; i < 4; i++)
        msg_buf[4 + i] = sb.swap_mode ? s[31 - 8*i -: 8] : s[8*i +: 8];
    cut = msg_buf.size();
    for (int i = 0; i < cut; i++) push_byte(msg_buf[i], i == cut - 1);
  endtask

  // output side: random stalls if out_stall_on; checks each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{out_event_res, out_byte_out, out_var_number, out_var_type_code,
                          out_var_length, out_byte_offset, out_var_last,
                          out_msg_type, out_message_done, out_error_code});
      out_ready <= out_stall_on ? ($urandom_range(0, 99) < 70) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.reset_all();
    idle_cycles = 0; bytes_sent = 0; out_stall_on = 0;
    rst_n = 0; in_valid = 0; in_data_byte = 0; in_last_byte = 0;
    cfg_valid = 0; cfg_index = vmsp_pkg::CFG_SWAP; cfg_data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every error, zero vars, trailing bytes
    build_msg(0, 0, 0);
    build_msg(2, 0, 3);
    build_msg(1, 1, 2);
    build_msg(1, 2, 2);
    build_msg(2, 3, 3);
    build_msg(1, 4, 1);
    build_msg(1, 5, 1);
    push_byte(8'hFF, 1);
    push_byte(8'h00, 1);
    wait_drained();
    write_cfg(vmsp_pkg::CFG_SWAP, 1); write_cfg(vmsp_pkg::CFG_NONAMES, 1);
    write_cfg(vmsp_pkg::CFG_MIN, 32'hFFFF_FFFF); write_cfg(vmsp_pkg::CFG_MAX, 32'hFFFF_FFFF);
    build_msg(2, 0, 2);
    build_msg(1, 1, 1);
    wait_drained();

    out_stall_on = 1;
    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      write_cfg(vmsp_pkg::CFG_SWAP, $urandom_range(0, 1));
      write_cfg(vmsp_pkg::CFG_NONAMES, $urandom_range(0, 1));
      case (phase_no)
        0: begin
          write_cfg(vmsp_pkg::CFG_MIN, 0); write_cfg(vmsp_pkg::CFG_MAX, 32'hFFFF_FFFF);
        end
        1: begin
          write_cfg(vmsp_pkg::CFG_MIN, 0); write_cfg(vmsp_pkg::CFG_MAX, 0);
        end
        default: begin
          write_cfg(vmsp_pkg::CFG_MIN, $urandom_range(0, 100));
          write_cfg(vmsp_pkg::CFG_MAX, $urandom_range(100, 5000));
        end
      endcase
      while (bytes_sent < 220 * (phase_no + 1)) begin
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) build_msg($urandom_range(0, 3), 0, 6);
        else if (k < 90) build_msg($urandom_range(1, 3), $urandom_range(1, 5), 6);
        else push_byte($urandom, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d messages, %0d parsed cleanly; %0d results checked.",
             bytes_sent, sb.msgs, sb.done_msgs, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
